>>> src/dag_edge_insert_cycle_check_assert.svh
// Assertion macros used by the checker file.
`ifndef DAG_EDGE_INSERT_CYCLE_CHECK_ASSERT_SVH
`define DAG_EDGE_INSERT_CYCLE_CHECK_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define DAGC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dagc assertion failed");

// Consequent checked in the cycle after the antecedent.
`define DAGC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dagc assertion failed");

`endif

>>> src/dagc_pkg.sv
`timescale 1ns / 1ps
package dagc_pkg;

  // Default sizing
  localparam int DEF_MAX_EDGES       = 64;
  localparam int DEF_NODE_ID_BITS    = 8;
  localparam int DEF_INNOVATION_BITS = 16;

  // Fixed field widths on the ports
  localparam int NODE_FIELD_W  = 8;
  localparam int OUTCOME_W     = 3;
  localparam int INNOV_FIELD_W = 16;
  localparam int TOTAL_W       = 7;

  // Result codes
  typedef enum logic [OUTCOME_W-1:0] {
    OUT_REENABLED = 3'd0,
    OUT_CYCLE     = 3'd1,
    OUT_INSERTED  = 3'd2,
    OUT_FULL      = 3'd3,
    OUT_CLEARED   = 3'd4
  } dagc_outcome_t;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_INIT,
    OP_LOAD,
    OP_CLEAR,
    OP_SCAN,
    OP_MARK,
    OP_UNMARK,
    OP_INSERT,
    OP_FINISH
  } dagc_op_t;

  // Kind of pass over the edge table
  typedef enum logic [1:0] {
    SCAN_LOOKUP,
    SCAN_REACH,
    SCAN_CLEAN
  } dagc_scan_t;

  typedef struct packed {
    dagc_op_t      op;
    dagc_scan_t    scan;
    dagc_outcome_t code;
  } dagc_cmd_t;

  typedef struct packed {
    logic item_clear;
    logic self_loop;
    logic full;
    logic busy;
    logic hit;
    logic grew;
    logic found;
    logic init_last;
  } dagc_status_t;

endpackage

>>> src/dagc_ctrl.sv
`timescale 1ns / 1ps
module dagc_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  input  dagc_pkg::dagc_status_t status,
  output dagc_pkg::dagc_cmd_t    cmd
);
  import dagc_pkg::*;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DISPATCH,
    ST_LOOKUP,
    ST_MARK,
    ST_REACH_GO,
    ST_REACH,
    ST_CLEAN_GO,
    ST_CLEAN,
    ST_UNMARK,
    ST_DECIDE,
    ST_FINISH
  } state_t;

  state_t        state, state_next;
  dagc_outcome_t result_code, result_code_next;
  logic          out_valid_next;

  assign in_stall = (state != ST_IDLE);

  // Sequencing of one request
  always_comb begin
    state_next       = state;
    result_code_next = result_code;
    out_valid_next   = out_valid && out_stall;
    cmd.op           = OP_NONE;
    cmd.scan         = SCAN_LOOKUP;
    cmd.code         = result_code;
    unique case (state)
      ST_INIT: begin
        cmd.op = OP_INIT;
        if (status.init_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (status.item_clear) begin
          cmd.op           = OP_CLEAR;
          result_code_next = OUT_CLEARED;
          state_next       = ST_FINISH;
        end else begin
          cmd.op     = OP_SCAN;
          cmd.scan   = SCAN_LOOKUP;
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (!status.busy) begin
          priority if (status.hit) begin
            result_code_next = OUT_REENABLED;
            state_next       = ST_FINISH;
          end else if (status.self_loop) begin
            result_code_next = OUT_CYCLE;
            state_next       = ST_FINISH;
          end else begin
            state_next = ST_MARK;
          end
        end
      end
      ST_MARK: begin
        cmd.op     = OP_MARK;
        state_next = ST_REACH_GO;
      end
      ST_REACH_GO: begin
        cmd.op     = OP_SCAN;
        cmd.scan   = SCAN_REACH;
        state_next = ST_REACH;
      end
      ST_REACH: begin
        // repeat passes until nothing new is reached or the source turns up
        if (!status.busy) begin
          if (status.grew && !status.found) begin
            state_next = ST_REACH_GO;
          end else begin
            state_next = ST_CLEAN_GO;
          end
        end
      end
      ST_CLEAN_GO: begin
        cmd.op     = OP_SCAN;
        cmd.scan   = SCAN_CLEAN;
        state_next = ST_CLEAN;
      end
      ST_CLEAN: begin
        if (!status.busy) begin
          state_next = ST_UNMARK;
        end
      end
      ST_UNMARK: begin
        cmd.op     = OP_UNMARK;
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        priority if (status.found) begin
          result_code_next = OUT_CYCLE;
        end else if (status.full) begin
          result_code_next = OUT_FULL;
        end else begin
          cmd.op           = OP_INSERT;
          result_code_next = OUT_INSERTED;
        end
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        // load the output register once the previous result has gone
        if (!out_valid || !out_stall) begin
          cmd.op         = OP_FINISH;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_INIT;
      result_code <= OUT_REENABLED;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      result_code <= result_code_next;
      out_valid   <= out_valid_next;
    end
  end

endmodule

>>> src/dagc_datapath.sv
`timescale 1ns / 1ps
module dagc_datapath #(
  parameter int MAX_EDGES       = dagc_pkg::DEF_MAX_EDGES,
  parameter int NODE_ID_BITS    = dagc_pkg::DEF_NODE_ID_BITS,
  parameter int INNOVATION_BITS = dagc_pkg::DEF_INNOVATION_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  dagc_pkg::dagc_cmd_t                 cmd,
  output dagc_pkg::dagc_status_t              status,
  input  logic                                mode,
  input  logic [dagc_pkg::NODE_FIELD_W-1:0]   source_node,
  input  logic [dagc_pkg::NODE_FIELD_W-1:0]   dest_node,
  output logic [dagc_pkg::OUTCOME_W-1:0]      outcome,
  output logic [dagc_pkg::INNOV_FIELD_W-1:0]  innovation,
  output logic [dagc_pkg::TOTAL_W-1:0]        edge_total
);
  import dagc_pkg::*;

  localparam int IDX_W      = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CNT_W      = $clog2(MAX_EDGES + 1);
  localparam int NODE_COUNT = 1 << NODE_ID_BITS;

  typedef logic [NODE_ID_BITS-1:0] node_t;

  // Edge table (slots 0 .. slot_count-1 are in use) and reached-node bitmap
  node_t edge_src_mem [MAX_EDGES];
  node_t edge_dst_mem [MAX_EDGES];
  logic  node_mem     [NODE_COUNT];

  // Item and bookkeeping
  logic                       item_clear;
  node_t                      item_src, item_dst;
  logic [CNT_W-1:0]           slot_count;
  logic [INNOVATION_BITS-1:0] next_innov, innov_held;
  node_t                      init_idx;

  // Scan pipeline: issue, edge read, node read, evaluate
  logic             issuing;
  logic [CNT_W-1:0] scan_idx;
  dagc_scan_t       scan_kind;
  logic             p1_valid, p2_valid;
  node_t            e_src, e_dst, src2, dst2;
  logic             rs_q, rd_q;
  logic             prev_wr;
  node_t            prev_addr;
  logic             hit, grew, found;

  logic             scan_start, last_issue;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic             rs_eff, rd_eff, fire, match, clean_wr;
  logic             node_we, node_wdata;
  node_t            node_waddr;

  always_comb begin
    scan_start = (cmd.op == OP_SCAN);
    rd_addr    = scan_idx[IDX_W-1:0];
    wr_addr    = slot_count[IDX_W-1:0];
    last_issue = (scan_idx == slot_count - CNT_W'(1));
    // forward the write made by the edge just before
    rs_eff     = rs_q | (prev_wr && (prev_addr == src2));
    rd_eff     = rd_q | (prev_wr && (prev_addr == dst2));
    fire       = p2_valid && (scan_kind == SCAN_REACH) && rs_eff && !rd_eff;
    match      = p2_valid && (scan_kind == SCAN_LOOKUP) &&
                 (src2 == item_src) && (dst2 == item_dst);
    clean_wr   = p2_valid && (scan_kind == SCAN_CLEAN);
  end

  // Single write port of the reached-node bitmap
  always_comb begin
    node_we    = 1'b0;
    node_waddr = dst2;
    node_wdata = 1'b0;
    priority if (cmd.op == OP_INIT) begin
      node_we    = 1'b1;
      node_waddr = init_idx;
    end else if (cmd.op == OP_MARK) begin
      node_we    = 1'b1;
      node_waddr = item_dst;
      node_wdata = 1'b1;
    end else if (cmd.op == OP_UNMARK) begin
      node_we    = 1'b1;
      node_waddr = item_dst;
    end else if (fire) begin
      node_we    = 1'b1;
      node_wdata = 1'b1;
    end else if (clean_wr) begin
      node_we    = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= '0;
      next_innov <= '0;
      init_idx   <= '0;
      issuing    <= 1'b0;
      scan_idx   <= '0;
      p1_valid   <= 1'b0;
      p2_valid   <= 1'b0;
      prev_wr    <= 1'b0;
      hit        <= 1'b0;
      grew       <= 1'b0;
      found      <= 1'b0;
    end else begin
      if (scan_start) begin
        scan_idx <= '0;
        issuing  <= (slot_count != '0);
      end else if (issuing) begin
        scan_idx <= scan_idx + CNT_W'(1);
        if (last_issue) begin
          issuing <= 1'b0;
        end
      end
      p1_valid <= issuing;
      p2_valid <= p1_valid;
      prev_wr  <= fire;

      if (scan_start) begin
        hit  <= 1'b0;
        grew <= 1'b0;
      end else begin
        if (match) hit <= 1'b1;
        if (fire) grew <= 1'b1;
      end

      if (cmd.op == OP_LOAD) begin
        found <= 1'b0;
      end else if (fire && (dst2 == item_src)) begin
        found <= 1'b1;
      end

      unique case (cmd.op)
        OP_INIT:   init_idx <= init_idx + node_t'(1);
        OP_CLEAR: begin
          slot_count <= '0;
          next_innov <= '0;
        end
        OP_INSERT: begin
          slot_count <= slot_count + CNT_W'(1);
          next_innov <= next_innov + INNOVATION_BITS'(1);
        end
        OP_NONE, OP_LOAD, OP_SCAN, OP_MARK, OP_UNMARK, OP_FINISH: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Memories and payload
  always_ff @(posedge clk) begin
    if (cmd.op == OP_INSERT) begin
      edge_src_mem[wr_addr] <= item_src;
      edge_dst_mem[wr_addr] <= item_dst;
    end
    e_src <= edge_src_mem[rd_addr];
    e_dst <= edge_dst_mem[rd_addr];

    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    rs_q      <= node_mem[e_src];
    rd_q      <= node_mem[e_dst];
    src2      <= e_src;
    dst2      <= e_dst;
    prev_addr <= dst2;

    if (scan_start) begin
      scan_kind <= cmd.scan;
    end

    if (cmd.op == OP_LOAD) begin
      item_clear <= mode;
      item_src   <= node_t'(source_node);
      item_dst   <= node_t'(dest_node);
      innov_held <= '0;
    end else if (cmd.op == OP_INSERT) begin
      innov_held <= next_innov;
    end

    if (cmd.op == OP_FINISH) begin
      outcome    <= cmd.code;
      innovation <= INNOV_FIELD_W'(innov_held);
      edge_total <= TOTAL_W'(slot_count);
    end
  end

  always_comb begin
    status.item_clear = item_clear;
    status.self_loop  = (item_src == item_dst);
    status.full       = (slot_count == CNT_W'(MAX_EDGES));
    status.busy       = issuing | p1_valid | p2_valid;
    status.hit        = hit;
    status.grew       = grew;
    status.found      = found;
    status.init_last  = &init_idx;
  end

endmodule

>>> src/dag_edge_insert_cycle_check.sv
`timescale 1ns / 1ps
// Channel   Handshake           Payload
// in        in_valid/in_stall   mode, source_node, dest_node
// out       out_valid/out_stall outcome, innovation, edge_total
//
// With E >= 1 valid edges a connect request ends after the lookup on an existing edge
// or a self-loop, else it runs P reachability passes (P <= E + 1), each paced by the
// one-edge-per-cycle scan over the edge table.
// After reset a clearing pass runs over all 2**NODE_ID_BITS entries of the
// reached-node bitmap before the first request is taken.
// A finished result waits in the output register while the next request runs.
module dag_edge_insert_cycle_check #(
  parameter int MAX_EDGES       = dagc_pkg::DEF_MAX_EDGES,
  parameter int NODE_ID_BITS    = dagc_pkg::DEF_NODE_ID_BITS,
  parameter int INNOVATION_BITS = dagc_pkg::DEF_INNOVATION_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                mode,
  input  logic [dagc_pkg::NODE_FIELD_W-1:0]   source_node,
  input  logic [dagc_pkg::NODE_FIELD_W-1:0]   dest_node,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [dagc_pkg::OUTCOME_W-1:0]      outcome,
  output logic [dagc_pkg::INNOV_FIELD_W-1:0]  innovation,
  output logic [dagc_pkg::TOTAL_W-1:0]        edge_total
);
  import dagc_pkg::*;

  dagc_cmd_t    cmd;
  dagc_status_t status;

  // Request sequencer
  dagc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Edge table, reached-node bitmap and scan pipeline
  dagc_datapath #(
    .MAX_EDGES       (MAX_EDGES),
    .NODE_ID_BITS    (NODE_ID_BITS),
    .INNOVATION_BITS (INNOVATION_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .mode        (mode),
    .source_node (source_node),
    .dest_node   (dest_node),
    .outcome     (outcome),
    .innovation  (innovation),
    .edge_total  (edge_total)
  );

endmodule

>>> src/dagc_checker.sv
`timescale 1ns / 1ps
`include "dag_edge_insert_cycle_check_assert.svh"
module dagc_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [dagc_pkg::OUTCOME_W-1:0]      outcome,
  input logic [dagc_pkg::INNOV_FIELD_W-1:0]  innovation,
  input logic [dagc_pkg::TOTAL_W-1:0]        edge_total
);
  import dagc_pkg::*;

  // a held result keeps its fields
  `DAGC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(outcome) && $stable(innovation) && $stable(edge_total))

  // one request at a time: intake closes right after an accept
  `DAGC_ASSERT_NEXT(a_intake_closes, clk, rst, in_valid && !in_stall, in_stall)

  // a clear leaves an empty table and no number
  `DAGC_ASSERT_NOW(a_clear_empty, clk, rst, out_valid && (outcome == OUT_CLEARED), (edge_total == '0) && (innovation == '0))

  // only an insertion carries a number
  `DAGC_ASSERT_NOW(a_innov_only_insert, clk, rst, out_valid && (outcome != OUT_INSERTED), innovation == '0)

  // an insertion always leaves at least one edge
  `DAGC_ASSERT_NOW(a_insert_nonempty, clk, rst, out_valid && (outcome == OUT_INSERTED), edge_total != '0)

endmodule

bind dag_edge_insert_cycle_check dagc_checker u_dagc_checker (.*);
